@@ hdl/frs_pkg.sv @@
// frs_pkg: shared types and constants of the fragment reassembler
// used by frs_ctrl, frs_dp and fragment_reassembler; depends on nothing

package frs_pkg;

  localparam int unsigned HEADER_BYTES = 9;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned HDR_W        = 64;

  // flags byte of a fragment header
  localparam int unsigned FLAG_FIRST_BIT = 0;
  localparam int unsigned FLAG_LAST_BIT  = 1;

  // position of the last header byte within a frame (type byte is position 0)
  localparam logic [POS_W-1:0] HDR_LAST_POS = POS_W'(HEADER_BYTES - 1);

  typedef enum logic [1:0] {
    CFG_NORMAL_CODE  = 2'd0,
    CFG_FRAG_CODE    = 2'd1,
    CFG_FRAG_VERSION = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_IGNORE  = 2'd0,
    CLS_NORMAL  = 2'd1,
    CLS_HEADER  = 2'd2,
    CLS_PAYLOAD = 2'd3
  } frame_class_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_LOAD = 2'd1,
    ST_EMIT = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic drop;          // clear the assembly in progress
    logic hdr_clear;     // empty the header register
    logic hdr_shift;     // shift the incoming byte into the header
    logic hdr_check;     // judge the completed header
    logic store_wr;      // append payload byte to the store
    logic frame_done;    // end of an accepted fragment frame
    logic pt_load;       // load the pass-through output register
    logic emit_first;    // read store entry 0
    logic emit_next;     // read the following store entry
    logic out_sel_store; // output shows store data
  } frs_cmd_t;

  typedef struct packed {
    logic is_normal;
    logic is_fragment;
    logic hdr_accept;
    logic emit_start;
    logic emit_last;
  } frs_stat_t;

endpackage

@@ hdl/frs_ctrl.sv @@
// frs_ctrl: frame tracking and emission state machine of the reassembler
// depends on frs_pkg; drives frs_dp through frs_cmd_t, reads frs_stat_t

module frs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_start_i,
  input  logic             in_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  frs_pkg::frs_stat_t stat_i,
  output frs_pkg::frs_cmd_t  cmd_o
);

  frs_pkg::ctrl_state_e  state_q, state_d;
  frs_pkg::frame_class_e class_q, class_d;
  logic [frs_pkg::POS_W-1:0] pos_q, pos_d;
  logic pt_valid_q, pt_valid_d;
  logic run_ready;
  logic beat;

  assign run_ready  = !pt_valid_q || out_ready_i;
  assign in_ready_o = (state_q == frs_pkg::ST_RUN) && run_ready;
  assign beat       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frs_pkg::ST_RUN: begin
        if (beat && stat_i.emit_start) state_d = frs_pkg::ST_LOAD;
      end
      frs_pkg::ST_LOAD: state_d = frs_pkg::ST_EMIT;
      frs_pkg::ST_EMIT: begin
        if (out_ready_i && stat_i.emit_last) state_d = frs_pkg::ST_RUN;
      end
      default: state_d = frs_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_o = 1'b0;
    class_d     = class_q;
    pos_d       = pos_q;
    pt_valid_d  = pt_valid_q;
    unique case (state_q)
      frs_pkg::ST_RUN: begin
        out_valid_o = pt_valid_q;
        if (out_ready_i) pt_valid_d = 1'b0;
        if (beat) begin
          if (in_start_i) begin
            cmd_o.hdr_clear = 1'b1;
            pos_d = frs_pkg::POS_W'(1);
            if (stat_i.is_normal) begin
              cmd_o.drop = 1'b1;
              class_d    = frs_pkg::CLS_NORMAL;
            end else if (stat_i.is_fragment) begin
              // a cut frame drops the assembly
              cmd_o.drop = (pos_q != '0);
              class_d    = frs_pkg::CLS_HEADER;
            end else begin
              cmd_o.drop = 1'b1;
              class_d    = frs_pkg::CLS_IGNORE;
            end
          end else if (pos_q != '0) begin
            case (class_q)
              frs_pkg::CLS_NORMAL: begin
                cmd_o.pt_load = 1'b1;
                pt_valid_d    = 1'b1;
              end
              frs_pkg::CLS_HEADER: begin
                cmd_o.hdr_shift = 1'b1;
                pos_d = pos_q + frs_pkg::POS_W'(1);
                if (pos_q == frs_pkg::HDR_LAST_POS) begin
                  cmd_o.hdr_check = 1'b1;
                  class_d = stat_i.hdr_accept ? frs_pkg::CLS_PAYLOAD : frs_pkg::CLS_IGNORE;
                end
              end
              frs_pkg::CLS_PAYLOAD: cmd_o.store_wr = 1'b1;
              default: ;
            endcase
          end
          if (in_end_i) begin
            // short fragment frame
            if (class_d == frs_pkg::CLS_HEADER) cmd_o.drop = 1'b1;
            cmd_o.frame_done = (class_d == frs_pkg::CLS_PAYLOAD);
            cmd_o.hdr_clear  = 1'b1;
            pos_d   = '0;
            class_d = frs_pkg::CLS_IGNORE;
          end
        end
      end
      frs_pkg::ST_LOAD: begin
        cmd_o.emit_first = 1'b1;
      end
      frs_pkg::ST_EMIT: begin
        out_valid_o         = 1'b1;
        cmd_o.out_sel_store = 1'b1;
        if (out_ready_i && !stat_i.emit_last) cmd_o.emit_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= frs_pkg::ST_RUN;
      class_q    <= frs_pkg::CLS_IGNORE;
      pos_q      <= '0;
      pt_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      class_q    <= class_d;
      pos_q      <= pos_d;
      pt_valid_q <= pt_valid_d;
    end
  end

endmodule

@@ hdl/frs_dp.sv @@
// frs_dp: datapath of the reassembler: config registers, header register,
// assembly state, message store and output registers; depends on frs_pkg

module frs_dp #(
  parameter int unsigned MAX_MESSAGE = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               rx_end_i,
  input  frs_pkg::frs_cmd_t  cmd_i,
  output frs_pkg::frs_stat_t stat_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_MESSAGE + 1);
  localparam int unsigned ADDR_W = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;

  logic [7:0] normal_code_q, frag_code_q, version_q;

  logic [frs_pkg::HDR_W-1:0] hdr_q, hdr_next;
  logic [7:0]  hdr_version;
  logic [15:0] hdr_seq;
  logic [31:0] hdr_total;
  logic        hdr_first, hdr_bad, eff_active, last_flag;
  logic [15:0] eff_seq;
  logic [CNT_W-1:0] eff_len;

  logic             active_q, active_d;
  logic [15:0]      seq_q, seq_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] emit_len_q, emit_len_d;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic             emit_start;

  logic [7:0]        store_mem [MAX_MESSAGE];
  logic [ADDR_W-1:0] rd_addr_q, rd_addr_d;
  logic              rd_en;
  logic [7:0]        rdata_q;
  logic [7:0]        pt_byte_q;
  logic              pt_last_q;
  logic              emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_code_q <= 8'h00;
      frag_code_q   <= 8'h01;
      version_q     <= 8'h01;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        frs_pkg::CFG_NORMAL_CODE:  normal_code_q <= cfg_wdata_i;
        frs_pkg::CFG_FRAG_CODE:    frag_code_q   <= cfg_wdata_i;
        frs_pkg::CFG_FRAG_VERSION: version_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // header fills from the top, so after eight bytes the flags sit lowest
  assign hdr_next    = {rx_byte_i, hdr_q[frs_pkg::HDR_W-1:8]};
  assign hdr_first   = hdr_next[frs_pkg::FLAG_FIRST_BIT];
  assign hdr_version = hdr_next[15:8];
  assign hdr_seq     = hdr_next[31:16];
  assign hdr_total   = hdr_next[63:32];

  assign hdr_bad    = (hdr_version != version_q) || (hdr_total == 32'd0) ||
                      (hdr_total > 32'(MAX_MESSAGE));
  // values as they stand after a possible restart by the first flag
  assign eff_active = hdr_first || active_q;
  assign eff_seq    = hdr_first ? 16'd0 : seq_q;
  assign eff_len    = hdr_first ? hdr_total[CNT_W-1:0] : len_q;

  assign stat_o.is_normal   = (rx_byte_i == normal_code_q);
  assign stat_o.is_fragment = (rx_byte_i == frag_code_q);
  assign stat_o.hdr_accept  = !hdr_bad && eff_active && (hdr_seq == eff_seq) &&
                              (hdr_total == 32'(eff_len));
  assign stat_o.emit_start  = emit_start;
  assign stat_o.emit_last   = emit_last;

  assign last_flag = cmd_i.hdr_check ? hdr_next[frs_pkg::FLAG_LAST_BIT]
                                     : hdr_q[frs_pkg::FLAG_LAST_BIT];

  always_comb begin
    active_d   = active_q;
    seq_d      = seq_q;
    len_d      = len_q;
    count_d    = count_q;
    emit_len_d = emit_len_q;
    wr_en      = 1'b0;
    wr_addr    = count_q[ADDR_W-1:0];
    emit_start = 1'b0;
    if (cmd_i.drop) begin
      active_d = 1'b0;
      seq_d    = '0;
      len_d    = '0;
      count_d  = '0;
    end
    if (cmd_i.hdr_check) begin
      if (!hdr_bad && hdr_first) begin
        active_d = 1'b1;
        seq_d    = '0;
        len_d    = eff_len;
        count_d  = '0;
      end
      if (!stat_o.hdr_accept) begin
        active_d = 1'b0;
        seq_d    = '0;
        len_d    = '0;
        count_d  = '0;
      end
    end
    if (cmd_i.store_wr && (count_d < len_d)) begin
      wr_en   = 1'b1;
      wr_addr = count_d[ADDR_W-1:0];
      count_d = count_d + CNT_W'(1);
    end
    if (cmd_i.frame_done) begin
      seq_d = seq_d + 16'd1;
      if (last_flag && (count_d >= len_d)) begin
        emit_start = 1'b1;
        emit_len_d = count_d;
        active_d   = 1'b0;
        seq_d      = '0;
        len_d      = '0;
        count_d    = '0;
      end
    end
  end

  assign rd_en     = cmd_i.emit_first || cmd_i.emit_next;
  assign rd_addr_d = cmd_i.emit_first ? '0 : rd_addr_q + ADDR_W'(1);
  assign emit_last = (CNT_W'(rd_addr_q) == (emit_len_q - CNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      seq_q      <= '0;
      len_q      <= '0;
      count_q    <= '0;
      emit_len_q <= '0;
      rd_addr_q  <= '0;
    end else begin
      active_q   <= active_d;
      seq_q      <= seq_d;
      len_q      <= len_d;
      count_q    <= count_d;
      emit_len_q <= emit_len_d;
      if (rd_en) rd_addr_q <= rd_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_clear) begin
      hdr_q <= '0;
    end else if (cmd_i.hdr_shift) begin
      hdr_q <= hdr_next;
    end
    if (cmd_i.pt_load) begin
      pt_byte_q <= rx_byte_i;
      pt_last_q <= rx_end_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[wr_addr] <= rx_byte_i;
    if (rd_en) rdata_q <= store_mem[rd_addr_d];
  end

  assign out_byte_o = cmd_i.out_sel_store ? rdata_q : pt_byte_q;
  assign out_last_o = cmd_i.out_sel_store ? emit_last : pt_last_q;

endmodule

@@ hdl/fragment_reassembler.sv @@
// fragment_reassembler: top level, joins the controller and the datapath
// depends on frs_pkg, frs_ctrl and frs_dp
//
// Received frames come in one byte per beat, tuser marking the type byte and
// tlast the final byte. Bytes of a normal frame go out through a one-deep
// output register, so intake runs at one beat per cycle while the output side
// keeps up. When the last fragment of a message completes, intake stops while
// the store drains over its single read port: a first read of entry 0, then
// one byte per cycle while the output side keeps up. The store needs no
// clearing pass after reset.

module fragment_reassembler #(
  parameter int unsigned MAX_MESSAGE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
  input  logic       s_axis_tuser,  // [0] frame_start
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] message_byte
  output logic       m_axis_tuser,  // [0] from_fragments
  output logic       m_axis_tlast
);

  frs_pkg::frs_cmd_t  cmd;
  frs_pkg::frs_stat_t stat;

  frs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_start_i  (s_axis_tuser),
    .in_end_i    (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  frs_dp #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (s_axis_tdata),
    .rx_end_i    (s_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = cmd.out_sel_store;

endmodule

@@ hdl/frs_checker.sv @@
// frs_checker: port-level assertions for fragment_reassembler
// bound to the top level below; depends on nothing else

module frs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // intake is closed while a reassembled message drains
  a_no_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !s_axis_tready)
    else $error("input ready during reassembled message");

  // a reassembled message goes out without gaps up to its last byte
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser)
    else $error("reassembled message broken off");

endmodule

bind fragment_reassembler frs_checker u_frs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ sim/tb_fragment_reassembler.sv @@
`timescale 1ns / 1ps
// tb_fragment_reassembler: self-checking bench for the fragment reassembler
// depends on frs_pkg and fragment_reassembler; predicts every output beat

module tb_fragment_reassembler;

  localparam int MAX_MESSAGE   = 64;
  localparam int SETTLE_CYCLES = MAX_MESSAGE + 8;
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int PHASE_BEATS   = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       frag;
  } msg_beat_t;

  typedef enum logic [1:0] {
    ROW_WRITE_REG,
    ROW_CHECKED,
    ROW_SILENT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    frs_pkg::cfg_idx_e  reg_idx;
    logic [7:0]         data;
    logic               sop;
    logic               eop;
    logic [7:0]         want_data;
    logic               want_last;
    logic               want_frag;
  } dir_row_t;

  // kind, register, data, start, end, expected byte, expected last, expected from_fragments
  localparam dir_row_t DIRECTED [27] = '{
    // normal frame carrying both byte extremes
    '{ROW_SILENT,    frs_pkg::CFG_NORMAL_CODE,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_TYPED,     frs_pkg::CFG_NORMAL_CODE,  8'hFF, 1'b0, 1'b0, 8'hFF, 1'b0, 1'b0},
    '{ROW_TYPED,     frs_pkg::CFG_NORMAL_CODE,  8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
    // type byte alone, then a byte with no frame open, then an unknown type
    '{ROW_SILENT,    frs_pkg::CFG_NORMAL_CODE,  8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
    '{ROW_SILENT,    frs_pkg::CFG_NORMAL_CODE,  8'hA5, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
    '{ROW_SILENT,    frs_pkg::CFG_NORMAL_CODE,  8'h7E, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
    // fragment frame that ends inside its header
    '{ROW_SILENT,    frs_pkg::CFG_NORMAL_CODE,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_SILENT,    frs_pkg::CFG_NORMAL_CODE,  8'h03, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_SILENT,    frs_pkg::CFG_NORMAL_CODE,  8'h01, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
    // normal frame cut off by the next type byte, so no last flag
    '{ROW_SILENT,    frs_pkg::CFG_NORMAL_CODE,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_TYPED,     frs_pkg::CFG_NORMAL_CODE,  8'h5A, 1'b0, 1'b0, 8'h5A, 1'b0, 1'b0},
    // single fragment, first and last, total 1, one byte too many
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h03, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h80, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_CHECKED,   frs_pkg::CFG_NORMAL_CODE,  8'h7F, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
    // one code for both frame types: treated as normal
    '{ROW_WRITE_REG, frs_pkg::CFG_NORMAL_CODE,  8'h42, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_WRITE_REG, frs_pkg::CFG_FRAG_CODE,    8'h42, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_WRITE_REG, frs_pkg::CFG_FRAG_VERSION, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_SILENT,    frs_pkg::CFG_NORMAL_CODE,  8'h42, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{ROW_TYPED,     frs_pkg::CFG_NORMAL_CODE,  8'h99, 1'b0, 1'b1, 8'h99, 1'b1, 1'b0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_addr_i;
  logic [7:0] cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;  // [7:0] rx_byte
  logic       s_axis_tuser;  // [0] frame_start
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;  // [7:0] message_byte
  logic       m_axis_tuser;  // [0] from_fragments
  logic       m_axis_tlast;

  fragment_reassembler #(
    .MAX_MESSAGE(MAX_MESSAGE)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // predictor copy of the configuration and the assembly state
  logic [7:0]            norm_code;
  logic [7:0]            frag_code;
  logic [7:0]            frag_version;
  logic                  asm_active;
  logic [15:0]           exp_seq;
  logic [6:0]            exp_len;
  logic [7:0]            store [MAX_MESSAGE];
  logic [6:0]            store_count;
  logic [3:0]            frame_pos;
  logic [63:0]           hdr;
  frs_pkg::frame_class_e cls;

  msg_beat_t pending_bytes [$];

  int error_count;
  int cycle_count;
  int beats_sent;
  int beats_checked;
  int messages_sent;
  int reg_writes;
  int send_idle_pct;
  int recv_stall_pct;
  int send_calm;
  int recv_calm;

  // appends one predicted output beat
  function automatic void add_expected(logic [7:0] data, logic last, logic frag);
    msg_beat_t item;
    item.data     = data;
    item.last     = last;
    item.frag     = frag;
    pending_bytes = {pending_bytes, item};
  endfunction

  function automatic void drop_assembly();
    asm_active  = 1'b0;
    exp_seq     = '0;
    exp_len     = '0;
    store_count = '0;
  endfunction

  function automatic void judge_header();
    logic [7:0]  flags;
    logic [7:0]  version;
    logic [15:0] seq;
    logic [31:0] total;
    flags   = hdr[7:0];
    version = hdr[15:8];
    seq     = hdr[31:16];
    total   = hdr[63:32];
    if (version != frag_version || total == 0 || total > MAX_MESSAGE) begin
      drop_assembly();
      cls = frs_pkg::CLS_IGNORE;
      return;
    end
    if (flags[frs_pkg::FLAG_FIRST_BIT]) begin
      asm_active  = 1'b1;
      exp_seq     = '0;
      exp_len     = total[6:0];
      store_count = '0;
    end
    if (!asm_active) begin
      cls = frs_pkg::CLS_IGNORE;
      return;
    end
    if (seq != exp_seq || total != 32'(exp_len)) begin
      drop_assembly();
      cls = frs_pkg::CLS_IGNORE;
      return;
    end
    cls = frs_pkg::CLS_PAYLOAD;
  endfunction

  // returns how many output beats this input beat adds to pending_bytes
  function automatic int reassemble_beat(logic [7:0] b, logic sop, logic eop);
    int produced;
    int shift;
    produced = 0;
    if (sop) begin
      if (frame_pos != 0) drop_assembly();
      hdr       = '0;
      frame_pos = 4'd1;
      if (b == norm_code) begin
        drop_assembly();
        cls = frs_pkg::CLS_NORMAL;
      end else if (b == frag_code) begin
        cls = frs_pkg::CLS_HEADER;
      end else begin
        drop_assembly();
        cls = frs_pkg::CLS_IGNORE;
      end
    end else if (frame_pos == 0) begin
      return 0;
    end else if (cls == frs_pkg::CLS_NORMAL) begin
      add_expected(b, eop, 1'b0);
      produced = 1;
    end else if (cls == frs_pkg::CLS_HEADER) begin
      shift = 8 * ((int'(frame_pos) - 1) & 7);
      hdr = hdr | (64'(b) << shift);
      frame_pos = frame_pos + 4'd1;
      if (frame_pos >= frs_pkg::HEADER_BYTES) judge_header();
    end else if (cls == frs_pkg::CLS_PAYLOAD) begin
      if (store_count < exp_len && store_count < MAX_MESSAGE) begin
        store[store_count] = b;
        store_count = store_count + 7'd1;
      end
    end
    if (eop) begin
      if (cls == frs_pkg::CLS_HEADER) begin
        drop_assembly();
      end else if (cls == frs_pkg::CLS_PAYLOAD) begin
        exp_seq = exp_seq + 16'd1;
        if (hdr[frs_pkg::FLAG_LAST_BIT] && store_count >= exp_len) begin
          for (int i = 0; i < int'(store_count); i++) begin
            add_expected(store[i], i == int'(store_count) - 1, 1'b1);
          end
          produced = produced + int'(store_count);
          drop_assembly();
        end
      end
      frame_pos = '0;
      cls       = frs_pkg::CLS_IGNORE;
      hdr       = '0;
    end
    return produced;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (error_count < 40) begin
      $display("mismatch in %s: got %0h, expected %0h (cycle %0d)", what, got, want,
               cycle_count);
    end
    error_count++;
  endtask

  // one input beat; returns at the rising edge that accepts it
  task automatic send_beat(input logic [7:0] b, input logic sop, input logic eop,
                           output int produced);
    while (send_idle_pct != 0 && send_calm == 0 &&
           $urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(63) == 0) send_calm = 24;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = sop;
    s_axis_tlast  = eop;
    do @(posedge clk_i); while (!s_axis_tready);
    produced = reassemble_beat(b, sop, eop);
    beats_sent++;
  endtask

  task automatic wait_drained(input int settle);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_register(input frs_pkg::cfg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = value;
    case (idx)
      frs_pkg::CFG_NORMAL_CODE:  norm_code    = value;
      frs_pkg::CFG_FRAG_CODE:    frag_code    = value;
      frs_pkg::CFG_FRAG_VERSION: frag_version = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    reg_writes++;
  endtask

  task automatic send_frame(input logic [7:0] bytes [$], input bit close);
    int n;
    foreach (bytes[i]) begin
      send_beat(bytes[i], i == 0, close && i == bytes.size() - 1, n);
    end
  endtask

  // one message split into fragments, now and then with a damaged fragment
  task automatic send_message();
    int          total;
    int          sent;
    int          room;
    int          plen;
    int          hdr_len;
    bit          done;
    bit          closing;
    logic [7:0]  flags;
    logic [7:0]  version;
    logic [15:0] seq;
    logic [15:0] seq_field;
    logic [31:0] total_field;
    logic [71:0] hdr_bits;
    logic [7:0]  frame [$];
    total = ($urandom_range(7) == 0) ? $urandom_range(MAX_MESSAGE, 17) : $urandom_range(16, 1);
    sent  = 0;
    seq   = '0;
    done  = 1'b0;
    messages_sent++;
    while (!done) begin
      room = (total - sent < 12) ? total - sent : 12;
      plen = (room == 0 || $urandom_range(7) == 0) ? 0 : $urandom_range(room, 1);
      done = (sent + plen >= total);
      flags = 8'($urandom_range(255));
      flags[frs_pkg::FLAG_FIRST_BIT] = (seq == 0);
      flags[frs_pkg::FLAG_LAST_BIT]  = done;
      version     = frag_version;
      seq_field   = seq;
      total_field = total;
      closing     = 1'b1;
      hdr_len     = frs_pkg::HEADER_BYTES;
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(7))
          0: version = frag_version ^ 8'($urandom_range(255, 1));
          1: total_field = '0;
          2: begin
            total_field = $urandom;
            if (total_field <= MAX_MESSAGE) total_field = total_field + MAX_MESSAGE + 1;
          end
          3: seq_field = seq ^ 16'($urandom_range(65535, 1));
          4: total_field = (total % MAX_MESSAGE) + 1;
          5: hdr_len = $urandom_range(frs_pkg::HEADER_BYTES - 1, 1);
          6: closing = 1'b0;
          default: begin
            flags[frs_pkg::FLAG_FIRST_BIT] = ~flags[frs_pkg::FLAG_FIRST_BIT];
            flags[frs_pkg::FLAG_LAST_BIT]  = 1'($urandom_range(1));
          end
        endcase
      end
      hdr_bits = {total_field, seq_field, version, flags, frag_code};
      frame.delete();
      for (int i = 0; i < hdr_len; i++) frame = {frame, hdr_bits[8*i +: 8]};
      if (hdr_len == frs_pkg::HEADER_BYTES) begin
        repeat (plen) frame = {frame, 8'($urandom_range(255))};
        // trailing bytes past the total get dropped
        if (done && $urandom_range(5) == 0) begin
          repeat ($urandom_range(3, 1)) frame = {frame, 8'($urandom_range(255))};
        end
      end
      send_frame(frame, closing);
      seq  = seq + 16'd1;
      sent = sent + plen;
    end
  endtask

  task automatic send_noise(input int pick);
    logic [7:0] frame [$];
    int         n;
    frame.delete();
    if (pick < 80) begin
      frame = {frame, norm_code};
      repeat ($urandom_range(10)) frame = {frame, 8'($urandom_range(255))};
      send_frame(frame, $urandom_range(7) != 0);
    end else if (pick < 90) begin
      frame = {frame, 8'($urandom_range(255))};
      repeat ($urandom_range(4)) frame = {frame, 8'($urandom_range(255))};
      send_frame(frame, 1'b1);
    end else begin
      repeat ($urandom_range(3, 1)) begin
        send_beat(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), n);
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] ncode, input logic [7:0] fcode,
                           input logic [7:0] ver, input int idle_pct, input int stall_pct);
    int start;
    int pick;
    wait_drained(SETTLE_CYCLES);
    write_register(frs_pkg::CFG_NORMAL_CODE, ncode);
    write_register(frs_pkg::CFG_FRAG_CODE, fcode);
    write_register(frs_pkg::CFG_FRAG_VERSION, ver);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = beats_sent;
    while (beats_sent - start < PHASE_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 60) send_message();
      else send_noise(pick);
      // hold off now and then until the output side has caught up
      if ($urandom_range(11) == 0) wait_drained(0);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycle_count,
               pending_bytes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // output side: random stalls with calm stretches
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_calm > 0) begin
        recv_calm--;
        m_axis_tready = 1'b1;
      end else begin
        if ($urandom_range(63) == 0) recv_calm = 24;
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_output
    msg_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("beat with nothing pending", m_axis_tdata, 8'h00);
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata !== want.data) begin
          report_mismatch("message_byte", m_axis_tdata, want.data);
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("message_last", 8'(m_axis_tlast), 8'(want.last));
        end
        if (m_axis_tuser !== want.frag) begin
          report_mismatch("from_fragments", 8'(m_axis_tuser), 8'(want.frag));
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    int       produced;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = frs_pkg::CFG_NORMAL_CODE;
    cfg_wdata_i    = 8'h00;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    s_axis_tuser   = 1'b0;
    s_axis_tlast   = 1'b0;
    error_count    = 0;
    cycle_count    = 0;
    beats_sent     = 0;
    beats_checked  = 0;
    messages_sent  = 0;
    reg_writes     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_calm      = 0;
    recv_calm      = 0;
    norm_code      = 8'h00;
    frag_code      = 8'h01;
    frag_version   = 8'h01;
    drop_assembly();
    frame_pos      = '0;
    hdr            = '0;
    cls            = frs_pkg::CLS_IGNORE;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      if (row.kind == ROW_WRITE_REG) begin
        wait_drained(SETTLE_CYCLES);
        write_register(row.reg_idx, row.data);
      end else begin
        send_beat(row.data, row.sop, row.eop, produced);
        if (row.kind != ROW_CHECKED) begin
          // hand-written expectation replaces the predicted one
          repeat (produced) void'(pending_bytes.pop_back());
          if (row.kind == ROW_TYPED) begin
            add_expected(row.want_data, row.want_last, row.want_frag);
          end
        end
      end
    end

    run_phase(8'h00, 8'h01, 8'h01, 0, 0);
    run_phase(8'hFF, 8'h00, 8'h00, 82, 0);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)), 0, 82);
    run_phase(8'h80, 8'h7F, 8'hFF, 19, 19);
    wait_drained(SETTLE_CYCLES);

    $display("sent %0d input beats in %0d fragmented messages plus noise frames, %0d %s",
             beats_sent, messages_sent, reg_writes, "register writes");
    $display("checked %0d output beats across four pacing phases, %0d mismatches",
             beats_checked, error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/frs_pkg.sv
hdl/frs_ctrl.sv
hdl/frs_dp.sv
hdl/fragment_reassembler.sv
hdl/frs_checker.sv
sim/tb_fragment_reassembler.sv
